### rtl/coalescing_deferred_request_table_unit_assert.svh
// Assertion macros used by the checker file of the deferred request table
`ifndef COALESCING_DEFERRED_REQUEST_TABLE_UNIT_ASSERT_SVH
`define COALESCING_DEFERRED_REQUEST_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define CDRT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define CDRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/cdrt_pkg.sv
// Types and constants of the deferred request table
`timescale 1ns / 1ps

package cdrt_pkg;

   localparam int KIND_BITS         = 3;
   localparam int OUTCOME_BITS      = 3;
   localparam int EMIT_HANDLER_BITS = 16;
   localparam int CTX_BITS          = 32;
   localparam int FLAG_BITS         = 32;
   localparam int STAT_BITS         = 32;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_DEFER       = 3'd0,
      KIND_CANCEL      = 3'd1,
      KIND_FLUSH       = 3'd2,
      KIND_BEGIN_BATCH = 3'd3,
      KIND_END_BATCH   = 3'd4,
      KIND_BEGIN_SYNC  = 3'd5,
      KIND_END_SYNC    = 3'd6,
      KIND_TAKE_STATS  = 3'd7
   } kind_type;

   typedef enum logic [OUTCOME_BITS-1:0] {
      OUT_INSERTED  = 3'd0,
      OUT_MERGED    = 3'd1,
      OUT_REJECTED  = 3'd2,
      OUT_FULL      = 3'd3,
      OUT_NOT_DEFER = 3'd4
   } outcome_type;

   // controller to datapath
   typedef struct packed {
      logic load_in;
      logic exec;
      logic flush_emit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      kind_type kind;
      logic     table_empty;
      logic     flush_last;
      logic     out_free;
   } dp_status_type;

endpackage

### rtl/cdrt_req_if.sv
// Request channel of the deferred request table
`timescale 1ns / 1ps

interface cdrt_req_if #(
   parameter int HANDLER_BITS = 16
);
   logic                             valid;
   logic                             ready;
   logic [cdrt_pkg::KIND_BITS-1:0]   kind;
   logic [HANDLER_BITS-1:0]          handler_id;
   logic [cdrt_pkg::CTX_BITS-1:0]    context_id;
   logic [cdrt_pkg::FLAG_BITS-1:0]   flag_bits;

   modport source (output valid, kind, handler_id, context_id, flag_bits, input ready);
   modport sink   (input valid, kind, handler_id, context_id, flag_bits, output ready);
endinterface

### rtl/cdrt_rsp_if.sv
// Response channel of the deferred request table
`timescale 1ns / 1ps

interface cdrt_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [cdrt_pkg::OUTCOME_BITS-1:0]       outcome;
   logic                                    emit_valid;
   logic [cdrt_pkg::EMIT_HANDLER_BITS-1:0]  emit_handler;
   logic [cdrt_pkg::CTX_BITS-1:0]           emit_context;
   logic [cdrt_pkg::FLAG_BITS-1:0]          emit_flags;
   logic                                    last;
   logic                                    batching;
   logic                                    any_pending;
   logic [cdrt_pkg::STAT_BITS-1:0]          stat_requests;
   logic [cdrt_pkg::STAT_BITS-1:0]          stat_merged;
   logic [cdrt_pkg::STAT_BITS-1:0]          stat_full;
   logic [cdrt_pkg::STAT_BITS-1:0]          stat_emitted;

   modport source (output valid, outcome, emit_valid, emit_handler, emit_context, emit_flags,
                   last, batching, any_pending, stat_requests, stat_merged, stat_full,
                   stat_emitted, input ready);
   modport sink   (input valid, outcome, emit_valid, emit_handler, emit_context, emit_flags,
                   last, batching, any_pending, stat_requests, stat_merged, stat_full,
                   stat_emitted, output ready);
endinterface

### rtl/cdrt_ctrl.sv
// Controller state machine of the deferred request table
`timescale 1ns / 1ps

module cdrt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  cdrt_pkg::dp_status_type status,
   output cdrt_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FLUSH
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load_in  = 1'b1;
               state_in     = S_EXEC;
               req_ready_in = 1'b0;
            end
         end
         S_EXEC: begin
            // wait for room in the result register
            if (status.out_free) begin
               cmd.exec = 1'b1;
               if (status.kind == cdrt_pkg::KIND_FLUSH && !status.table_empty) begin
                  state_in = S_FLUSH;
               end else begin
                  state_in     = S_IDLE;
                  req_ready_in = 1'b1;
               end
            end
         end
         S_FLUSH: begin
            if (status.out_free) begin
               cmd.flush_emit = 1'b1;
               if (status.flush_last) begin
                  state_in     = S_IDLE;
                  req_ready_in = 1'b1;
               end
            end
         end
         default: begin
            state_in     = S_IDLE;
            req_ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
      end
   end

   assign req_ready = req_ready_ff;

endmodule

### rtl/cdrt_dp.sv
// Datapath of the deferred request table: slot file, key compare, counters, result register
`timescale 1ns / 1ps

module cdrt_dp #(
   parameter int SLOTS        = 16,
   parameter int HANDLER_BITS = 16,
   parameter int NEST_BITS    = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cdrt_pkg::ctrl_cmd_type                 cmd,
   output cdrt_pkg::dp_status_type                status,
   input  logic [cdrt_pkg::KIND_BITS-1:0]         req_kind,
   input  logic [HANDLER_BITS-1:0]                req_handler_id,
   input  logic [cdrt_pkg::CTX_BITS-1:0]          req_context_id,
   input  logic [cdrt_pkg::FLAG_BITS-1:0]         req_flag_bits,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [cdrt_pkg::OUTCOME_BITS-1:0]      rsp_outcome,
   output logic                                   rsp_emit_valid,
   output logic [cdrt_pkg::EMIT_HANDLER_BITS-1:0] rsp_emit_handler,
   output logic [cdrt_pkg::CTX_BITS-1:0]          rsp_emit_context,
   output logic [cdrt_pkg::FLAG_BITS-1:0]         rsp_emit_flags,
   output logic                                   rsp_last,
   output logic                                   rsp_batching,
   output logic                                   rsp_any_pending,
   output logic [cdrt_pkg::STAT_BITS-1:0]         rsp_stat_requests,
   output logic [cdrt_pkg::STAT_BITS-1:0]         rsp_stat_merged,
   output logic [cdrt_pkg::STAT_BITS-1:0]         rsp_stat_full,
   output logic [cdrt_pkg::STAT_BITS-1:0]         rsp_stat_emitted
);

   localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int EH       = cdrt_pkg::EMIT_HANDLER_BITS;
   localparam int CB       = cdrt_pkg::CTX_BITS;
   localparam int FB       = cdrt_pkg::FLAG_BITS;
   localparam int SB       = cdrt_pkg::STAT_BITS;

   // latched item
   cdrt_pkg::kind_type    in_kind_ff;
   logic [HANDLER_BITS-1:0] in_handler_ff;
   logic [CB-1:0]         in_context_ff;
   logic [FB-1:0]         in_flags_ff;

   // slot file; a slot is live when its valid bit is set
   logic [SLOTS-1:0]        slot_valid_ff, slot_valid_in;
   logic [HANDLER_BITS-1:0] slot_handler_ff [SLOTS];
   logic [CB-1:0]           slot_context_ff [SLOTS];
   logic [FB-1:0]           slot_flags_ff   [SLOTS];
   logic [SLOTS-1:0]        flush_mask_ff, flush_mask_in;

   logic [NEST_BITS-1:0] batch_ff, batch_in, sync_ff, sync_in;
   logic [SB-1:0] cnt_req_ff, cnt_req_in, cnt_merge_ff, cnt_merge_in;
   logic [SB-1:0] cnt_full_ff, cnt_full_in, cnt_emit_ff, cnt_emit_in;

   // result register
   logic                          out_valid_ff;
   cdrt_pkg::outcome_type         out_outcome_ff, out_outcome_in;
   logic                          out_emit_ff, out_emit_in;
   logic [EH-1:0]                 out_handler_ff, out_handler_in;
   logic [CB-1:0]                 out_context_ff, out_context_in;
   logic [FB-1:0]                 out_flags_ff, out_flags_in;
   logic                          out_last_ff, out_last_in;
   logic                          out_batching_ff, out_batching_in;
   logic                          out_pending_ff, out_pending_in;
   logic [SB-1:0]                 out_sreq_ff, out_sreq_in, out_smerge_ff, out_smerge_in;
   logic [SB-1:0]                 out_sfull_ff, out_sfull_in, out_semit_ff, out_semit_in;
   logic                          out_load;

   logic [SLOTS-1:0]    match_vec;
   logic [IDX_BITS-1:0] match_idx, free_idx, flush_idx;
   logic                hit, has_free, gate_ok, do_insert, do_merge;

   // key compare and lowest-index pick
   always_comb begin
      match_idx = '0;
      free_idx  = '0;
      flush_idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         match_vec[i] = slot_valid_ff[i] && slot_handler_ff[i] == in_handler_ff
                        && slot_context_ff[i] == in_context_ff;
      end
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (match_vec[i])     match_idx = IDX_BITS'(i);
         if (!slot_valid_ff[i]) free_idx = IDX_BITS'(i);
         if (flush_mask_ff[i]) flush_idx = IDX_BITS'(i);
      end
      hit      = |match_vec;
      has_free = ~&slot_valid_ff;
      gate_ok  = in_handler_ff != '0 && in_flags_ff != '0 && batch_ff != '0 && sync_ff == '0;
   end

   assign do_insert = cmd.exec && in_kind_ff == cdrt_pkg::KIND_DEFER && gate_ok && !hit
                      && has_free;
   assign do_merge  = cmd.exec && in_kind_ff == cdrt_pkg::KIND_DEFER && gate_ok && hit;

   always_comb begin
      slot_valid_in   = slot_valid_ff;
      flush_mask_in   = flush_mask_ff;
      batch_in        = batch_ff;
      sync_in         = sync_ff;
      cnt_req_in      = cnt_req_ff;
      cnt_merge_in    = cnt_merge_ff;
      cnt_full_in     = cnt_full_ff;
      cnt_emit_in     = cnt_emit_ff;
      out_load        = 1'b0;
      out_outcome_in  = cdrt_pkg::OUT_NOT_DEFER;
      out_emit_in     = 1'b0;
      out_handler_in  = '0;
      out_context_in  = '0;
      out_flags_in    = '0;
      out_last_in     = 1'b1;
      out_sreq_in     = '0;
      out_smerge_in   = '0;
      out_sfull_in    = '0;
      out_semit_in    = '0;

      if (cmd.exec) begin
         out_load = 1'b1;
         unique case (in_kind_ff)
            cdrt_pkg::KIND_DEFER: begin
               if (!gate_ok) begin
                  out_outcome_in = cdrt_pkg::OUT_REJECTED;
               end else begin
                  cnt_req_in = cnt_req_ff + SB'(1);
                  if (hit) begin
                     out_outcome_in = cdrt_pkg::OUT_MERGED;
                     cnt_merge_in   = cnt_merge_ff + SB'(1);
                  end else if (has_free) begin
                     out_outcome_in          = cdrt_pkg::OUT_INSERTED;
                     slot_valid_in[free_idx] = 1'b1;
                  end else begin
                     out_outcome_in = cdrt_pkg::OUT_FULL;
                     cnt_full_in    = cnt_full_ff + SB'(1);
                  end
               end
            end
            cdrt_pkg::KIND_CANCEL: slot_valid_in = slot_valid_ff & ~match_vec;
            cdrt_pkg::KIND_FLUSH: begin
               // hand the live set to the flush sweep; an empty table answers at once
               flush_mask_in = slot_valid_ff;
               slot_valid_in = '0;
               out_load      = ~|slot_valid_ff;
            end
            cdrt_pkg::KIND_BEGIN_BATCH: if (batch_ff != '1) batch_in = batch_ff + NEST_BITS'(1);
            cdrt_pkg::KIND_END_BATCH:   if (batch_ff != '0) batch_in = batch_ff - NEST_BITS'(1);
            cdrt_pkg::KIND_BEGIN_SYNC:  if (sync_ff != '1) sync_in = sync_ff + NEST_BITS'(1);
            cdrt_pkg::KIND_END_SYNC:    if (sync_ff != '0) sync_in = sync_ff - NEST_BITS'(1);
            cdrt_pkg::KIND_TAKE_STATS: begin
               out_sreq_in   = cnt_req_ff;
               out_smerge_in = cnt_merge_ff;
               out_sfull_in  = cnt_full_ff;
               out_semit_in  = cnt_emit_ff;
               cnt_req_in    = '0;
               cnt_merge_in  = '0;
               cnt_full_in   = '0;
               cnt_emit_in   = '0;
            end
            default: ;
         endcase
      end else if (cmd.flush_emit) begin
         out_load                 = 1'b1;
         out_emit_in              = 1'b1;
         out_handler_in           = EH'(slot_handler_ff[flush_idx]);
         out_context_in           = slot_context_ff[flush_idx];
         out_flags_in             = slot_flags_ff[flush_idx];
         out_last_in              = status.flush_last;
         flush_mask_in[flush_idx] = 1'b0;
         cnt_emit_in              = cnt_emit_ff + SB'(1);
      end

      // batching and pending show the state after the step
      out_batching_in = batch_in != '0 && sync_in == '0;
      out_pending_in  = |slot_valid_in;
   end

   assign status.kind        = in_kind_ff;
   assign status.table_empty = ~|slot_valid_ff;
   assign status.flush_last  = (flush_mask_ff & (flush_mask_ff - SLOTS'(1))) == '0;
   assign status.out_free    = !out_valid_ff || rsp_ready;

   // slot payload, no reset
   always_ff @(posedge clock) begin
      if (do_insert) begin
         slot_handler_ff[free_idx] <= in_handler_ff;
         slot_context_ff[free_idx] <= in_context_ff;
         slot_flags_ff[free_idx]   <= in_flags_ff;
      end else if (do_merge) begin
         slot_flags_ff[match_idx]  <= slot_flags_ff[match_idx] | in_flags_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_kind_ff    <= cdrt_pkg::kind_type'(req_kind);
         in_handler_ff <= req_handler_id;
         in_context_ff <= req_context_id;
         in_flags_ff   <= req_flag_bits;
      end
      if (out_load) begin
         out_outcome_ff  <= out_outcome_in;
         out_emit_ff     <= out_emit_in;
         out_handler_ff  <= out_handler_in;
         out_context_ff  <= out_context_in;
         out_flags_ff    <= out_flags_in;
         out_last_ff     <= out_last_in;
         out_batching_ff <= out_batching_in;
         out_pending_ff  <= out_pending_in;
         out_sreq_ff     <= out_sreq_in;
         out_smerge_ff   <= out_smerge_in;
         out_sfull_ff    <= out_sfull_in;
         out_semit_ff    <= out_semit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         flush_mask_ff <= '0;
         batch_ff      <= '0;
         sync_ff       <= '0;
         cnt_req_ff    <= '0;
         cnt_merge_ff  <= '0;
         cnt_full_ff   <= '0;
         cnt_emit_ff   <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         flush_mask_ff <= flush_mask_in;
         batch_ff      <= batch_in;
         sync_ff       <= sync_in;
         cnt_req_ff    <= cnt_req_in;
         cnt_merge_ff  <= cnt_merge_in;
         cnt_full_ff   <= cnt_full_in;
         cnt_emit_ff   <= cnt_emit_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_outcome       = out_outcome_ff;
   assign rsp_emit_valid    = out_emit_ff;
   assign rsp_emit_handler  = out_handler_ff;
   assign rsp_emit_context  = out_context_ff;
   assign rsp_emit_flags    = out_flags_ff;
   assign rsp_last          = out_last_ff;
   assign rsp_batching      = out_batching_ff;
   assign rsp_any_pending   = out_pending_ff;
   assign rsp_stat_requests = out_sreq_ff;
   assign rsp_stat_merged   = out_smerge_ff;
   assign rsp_stat_full     = out_sfull_ff;
   assign rsp_stat_emitted  = out_semit_ff;

endmodule

### rtl/coalescing_deferred_request_table_unit.sv
// Top level of the coalescing deferred request table
`timescale 1ns / 1ps

// Table of up to SLOTS pending requests keyed by handler and context. Each
// request item passes an accept step, then an execute step in which every
// slot's key is compared in parallel and the table, the nesting counters and
// the event counters are updated. A flush reads the live entries out of the
// slot file through one port, one entry a cycle while the result register is
// free. The result register lets a new item be taken while a result waits; the
// execute step holds off until that register is free. Slot occupancy lives in
// valid flip-flops cleared by reset, so there is no clearing pass.
module coalescing_deferred_request_table_unit #(
   parameter int SLOTS        = 16,
   parameter int HANDLER_BITS = 16,
   parameter int NEST_BITS    = 8
) (
   input logic        clock,
   input logic        reset,
   cdrt_req_if.sink   req_bus,
   cdrt_rsp_if.source rsp_bus
);

   cdrt_pkg::ctrl_cmd_type  cmd;
   cdrt_pkg::dp_status_type status;
   logic [HANDLER_BITS-1:0] req_handler;

   assign req_handler = HANDLER_BITS'(req_bus.handler_id);

   cdrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cdrt_dp #(
      .SLOTS        (SLOTS),
      .HANDLER_BITS (HANDLER_BITS),
      .NEST_BITS    (NEST_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_bus.kind),
      .req_handler_id    (req_handler),
      .req_context_id    (req_bus.context_id),
      .req_flag_bits     (req_bus.flag_bits),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_outcome       (rsp_bus.outcome),
      .rsp_emit_valid    (rsp_bus.emit_valid),
      .rsp_emit_handler  (rsp_bus.emit_handler),
      .rsp_emit_context  (rsp_bus.emit_context),
      .rsp_emit_flags    (rsp_bus.emit_flags),
      .rsp_last          (rsp_bus.last),
      .rsp_batching      (rsp_bus.batching),
      .rsp_any_pending   (rsp_bus.any_pending),
      .rsp_stat_requests (rsp_bus.stat_requests),
      .rsp_stat_merged   (rsp_bus.stat_merged),
      .rsp_stat_full     (rsp_bus.stat_full),
      .rsp_stat_emitted  (rsp_bus.stat_emitted)
   );

endmodule

### rtl/cdrt_checker.sv
// Port checker of the deferred request table and its bind
`timescale 1ns / 1ps
`include "coalescing_deferred_request_table_unit_assert.svh"

module cdrt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [cdrt_pkg::OUTCOME_BITS-1:0] rsp_outcome,
   input logic                              rsp_emit_valid,
   input logic                              rsp_last,
   input logic                              rsp_any_pending
);

   // a waiting item stays offered
   `CDRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")

   // only a flush run has items before its last
   `CDRT_ASSERT_IMP(a_run_is_flush, clock, reset, rsp_valid && !rsp_last, rsp_emit_valid && rsp_outcome == cdrt_pkg::OUT_NOT_DEFER, "non-last item outside a flush run")

   // a flushed entry leaves the table empty
   `CDRT_ASSERT_IMP(a_flush_empties, clock, reset, rsp_valid && rsp_emit_valid, !rsp_any_pending, "pending after flush")

   // a defer answers with one plain item
   `CDRT_ASSERT_IMP(a_defer_single, clock, reset, rsp_valid && rsp_outcome != cdrt_pkg::OUT_NOT_DEFER, rsp_last && !rsp_emit_valid, "defer result malformed")

endmodule

bind coalescing_deferred_request_table_unit cdrt_checker u_cdrt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_outcome     (rsp_bus.outcome),
   .rsp_emit_valid  (rsp_bus.emit_valid),
   .rsp_last        (rsp_bus.last),
   .rsp_any_pending (rsp_bus.any_pending)
);
